/* hdl/espi_pkg.sv */
package espi_pkg;

  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_KP_GAIN = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KI_GAIN = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CPR     = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW  = 4'd3;

  localparam logic [15:0] KP_RESET     = 16'd256;
  localparam logic [15:0] KI_RESET     = 16'd256;
  localparam logic [15:0] CPR_RESET    = 16'd1024;
  localparam logic [15:0] WINDOW_RESET = 16'd100;

  localparam logic [15:0] RPM_SCALE = 16'd60000;
  localparam logic [9:0]  MS_PER_S  = 10'd1000;

  localparam int MUL_A_W   = 34;
  localparam int MUL_B_W   = 17;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int DSR_W     = 48;
  localparam int SPD_DIV_N = 48;
  localparam int QCLIP_W   = 34;
  localparam int ISAT_SH   = 40;
  localparam int ISAT_BIT  = 43;
  localparam int SUM_ACC_W = 52;

  // For any v below 2^16, v / 1000 equals (v * RECIP_1000) >> RECIP_SH.
  localparam int DIG_W      = 6;
  localparam int INT_DIGITS = 8;
  localparam int REM_DIGITS = 5;
  localparam int RECIP_SH   = 26;
  localparam logic [16:0] RECIP_1000 = 17'd67109;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_NUM,
    ST_MUL_DEN,
    ST_DIV_SPD,
    ST_SPEED,
    ST_MUL_P,
    ST_INTEG,
    ST_IABS,
    ST_DIV_INT,
    ST_MUL_Q,
    ST_MUL_R,
    ST_DIV_REM,
    ST_MUL_KP,
    ST_SUM,
    ST_FIN
  } state_t;

endpackage

/* hdl/encoder_speed_pi_motor_drive.sv */
// Channel | Direction | Handshake           | Beat contents
// in_     | input     | in_valid / in_stall | target_rpm, encoder_count, time_ms
// out_    | output    | out_valid/out_stall | drive_magnitude, forward, measured_rpm
// cfg_    | input     | cfg_valid/cfg_ready | register index, 16-bit data
//
// A beat is accepted only in the idle state. Its result is loaded when the sequence reaches
// the finish state and the output register is free, and only then is the next beat taken.
// A new speed sample costs the 48-step restoring divider for the speed; scaling the
// integral by 1/1000 takes 8 reciprocal digit steps and its remainder 5 more.
// Synchronous active-low reset restores the gains and clears all controller state.
// in_stall is high while a beat is in work, including while its result waits on out_stall.
module encoder_speed_pi_motor_drive #(
  parameter int INTEGRATOR_WIDTH = 48
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [15:0]             in_target_rpm,
  input  logic signed [31:0]             in_encoder_count,
  input  logic [31:0]                    in_time_ms,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     out_drive_magnitude,
  output logic                           out_forward,
  output logic signed [15:0]             out_measured_rpm,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [espi_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [espi_pkg::CFG_DAT_W-1:0] cfg_data
);
  import espi_pkg::*;

  localparam int IW    = INTEGRATOR_WIDTH;
  localparam int DV_W  = (IW > SPD_DIV_N) ? IW : SPD_DIV_N;
  localparam int CNT_W = $clog2(DV_W + 1);
  localparam int PW    = 49;
  localparam int SUM_W = ((IW > PW) ? IW : PW) + 1;
  localparam int SH1   = DV_W - SPD_DIV_N;
  localparam int SH2   = DV_W - INT_DIGITS * DIG_W;
  localparam int SH3   = DV_W - REM_DIGITS * DIG_W;
  localparam logic signed [SUM_W-1:0] IMAX_S =
    signed'((SUM_W'(1) << (IW - 1)) - SUM_W'(1));
  localparam logic signed [SUM_W-1:0] IMIN_S = -IMAX_S - SUM_W'(1);

  state_t state_r, state_nxt;

  logic [15:0] kp_r, ki_r, cpr_r, win_r;
  logic [31:0] last_samp_time_r, last_samp_count_r, last_ctrl_r;
  logic signed [15:0] held_r;
  logic signed [IW-1:0] integ_r;

  logic signed [15:0] target_r;
  logic [31:0] ctrl_dt_r, samp_dt_r, dabs_r;
  logic dneg_r;
  logic [SPD_DIV_N-1:0] num_r;
  logic [15:0] err_abs_r;
  logic err_neg_r;
  logic [47:0] prod_r;
  logic ineg_r, isat_r;
  logic [49:0] iq_r;
  logic [50:0] im_r;
  logic [31:0] kpe_r;
  logic signed [SUM_ACC_W-1:0] sum_r;

  logic [DSR_W-1:0] div_rem_r, div_dsr_r;
  logic [DV_W-1:0] div_quo_r;
  logic [CNT_W-1:0] div_cnt_r;

  logic out_valid_r, out_forward_r;
  logic [7:0] out_mag_r;
  logic signed [15:0] out_rpm_r;

  logic in_acc, out_load;
  logic [31:0] ctrl_dt_c, samp_dt_c, d_c, dabs_c;
  logic [15:0] win_eff, cpr_eff;
  logic samp_go;
  logic signed [16:0] err_c;
  logic [15:0] err_abs_c;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_res;
  logic [DSR_W:0] rem_sh, rem_sub;
  logic div_ge;
  logic div_last;
  logic [15:0] dig_v;
  logic [DIG_W-1:0] dig_q;
  logic [9:0] dig_r;
  logic signed [SUM_W-1:0] integ_ext, p_s, integ_sum;
  logic signed [IW-1:0] integ_sat;
  logic [IW-1:0] integ_abs;
  logic [DV_W-1:0] iabs_w;
  logic signed [SUM_ACC_W-1:0] kpe_s, iterm_s;
  logic [SUM_ACC_W-1:0] sum_mag;
  logic [SUM_ACC_W-9:0] pwm_mag;
  logic [7:0] drive_c;
  logic fwd_c;
  logic [DV_W-1:0] spd_q;
  logic signed [15:0] held_c;

  assign in_acc   = in_valid && !in_stall;
  assign out_load = (state_r == ST_FIN) && (!out_valid_r || !out_stall);

  assign win_eff   = (win_r == 16'd0) ? 16'd1 : win_r;
  assign cpr_eff   = (cpr_r == 16'd0) ? 16'd1 : cpr_r;
  assign ctrl_dt_c = in_time_ms - last_ctrl_r;
  assign samp_dt_c = in_time_ms - last_samp_time_r;
  assign d_c       = in_encoder_count - last_samp_count_r;
  assign dabs_c    = d_c[31] ? (32'd0 - d_c) : d_c;
  assign samp_go   = (samp_dt_c >= 32'(win_eff));

  assign err_c     = 17'(target_r) - 17'(held_r);
  assign err_abs_c = err_c[16] ? 16'(-err_c) : err_c[15:0];

  assign mul_res = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

  assign rem_sh   = {div_rem_r, div_quo_r[DV_W-1]};
  assign div_ge   = (rem_sh >= {1'b0, div_dsr_r});
  assign rem_sub  = div_ge ? (rem_sh - {1'b0, div_dsr_r}) : rem_sh;
  assign div_last = (div_cnt_r == CNT_W'(1));

  assign dig_v = {div_rem_r[9:0], div_quo_r[DV_W-1 -: DIG_W]};
  assign dig_q = mul_res[RECIP_SH +: DIG_W];
  assign dig_r = 10'(dig_v - 16'(dig_q) * 16'(MS_PER_S));

  assign spd_q = div_quo_r;
  always_comb begin
    if (dneg_r) begin
      held_c = (spd_q > DV_W'(32768)) ? -16'sd32768 : signed'(16'(-spd_q[15:0]));
    end else begin
      held_c = (spd_q > DV_W'(32767)) ? 16'sd32767 : signed'(spd_q[15:0]);
    end
  end

  always_comb begin
    integ_ext = SUM_W'(integ_r);
    p_s = signed'(SUM_W'(prod_r));
    if (err_neg_r) begin
      p_s = -p_s;
    end
    integ_sum = integ_ext + p_s;
    if (integ_sum > IMAX_S) begin
      integ_sat = IMAX_S[IW-1:0];
    end else if (integ_sum < IMIN_S) begin
      integ_sat = IMIN_S[IW-1:0];
    end else begin
      integ_sat = integ_sum[IW-1:0];
    end
  end

  assign integ_abs = integ_r[IW-1] ? IW'(-integ_r) : IW'(integ_r);
  assign iabs_w    = DV_W'(integ_abs);

  always_comb begin
    kpe_s   = signed'(SUM_ACC_W'(kpe_r));
    iterm_s = signed'(SUM_ACC_W'(im_r));
    if (err_neg_r) begin
      kpe_s = -kpe_s;
    end
    if (ineg_r) begin
      iterm_s = -iterm_s;
    end
  end

  assign sum_mag = sum_r[SUM_ACC_W-1] ? SUM_ACC_W'(-sum_r) : SUM_ACC_W'(sum_r);
  assign pwm_mag = sum_mag[SUM_ACC_W-1:8];
  assign drive_c = (|pwm_mag[SUM_ACC_W-9:8]) ? 8'hFF : pwm_mag[7:0];
  assign fwd_c   = !(sum_r[SUM_ACC_W-1] && (pwm_mag != '0));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:    if (in_acc) state_nxt = samp_go ? ST_MUL_NUM : ST_MUL_P;
      ST_MUL_NUM: state_nxt = ST_MUL_DEN;
      ST_MUL_DEN: state_nxt = ST_DIV_SPD;
      ST_DIV_SPD: if (div_last) state_nxt = ST_SPEED;
      ST_SPEED:   state_nxt = ST_MUL_P;
      ST_MUL_P:   state_nxt = ST_INTEG;
      ST_INTEG:   state_nxt = ST_IABS;
      ST_IABS:    state_nxt = ST_DIV_INT;
      ST_DIV_INT: if (div_last) state_nxt = ST_MUL_Q;
      ST_MUL_Q:   state_nxt = ST_MUL_R;
      ST_MUL_R:   state_nxt = ST_DIV_REM;
      ST_DIV_REM: if (div_last) state_nxt = ST_MUL_KP;
      ST_MUL_KP:  state_nxt = ST_SUM;
      ST_SUM:     state_nxt = ST_FIN;
      ST_FIN:     if (out_load) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state_r != ST_IDLE);
    cfg_ready = 1'b1;
    mul_a     = '0;
    mul_b     = '0;
    unique case (state_r)
      ST_MUL_NUM: begin
        mul_a = MUL_A_W'(dabs_r);
        mul_b = MUL_B_W'(RPM_SCALE);
      end
      ST_MUL_DEN: begin
        mul_a = MUL_A_W'(samp_dt_r);
        mul_b = MUL_B_W'(cpr_eff);
      end
      ST_MUL_P: begin
        mul_a = MUL_A_W'(ctrl_dt_r);
        mul_b = MUL_B_W'(err_abs_c);
      end
      ST_DIV_INT, ST_DIV_REM: begin
        mul_a = MUL_A_W'(dig_v);
        mul_b = MUL_B_W'(RECIP_1000);
      end
      ST_MUL_Q: begin
        mul_a = div_quo_r[QCLIP_W-1:0];
        mul_b = MUL_B_W'(ki_r);
      end
      ST_MUL_R: begin
        mul_a = MUL_A_W'(div_rem_r[9:0]);
        mul_b = MUL_B_W'(ki_r);
      end
      ST_MUL_KP: begin
        mul_a = MUL_A_W'(err_abs_r);
        mul_b = MUL_B_W'(kp_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= ST_IDLE;
      kp_r              <= KP_RESET;
      ki_r              <= KI_RESET;
      cpr_r             <= CPR_RESET;
      win_r             <= WINDOW_RESET;
      last_samp_time_r  <= '0;
      last_samp_count_r <= '0;
      last_ctrl_r       <= '0;
      held_r            <= '0;
      integ_r           <= '0;
      out_valid_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_KP_GAIN: kp_r  <= cfg_data;
          REG_KI_GAIN: ki_r  <= cfg_data;
          REG_CPR:     cpr_r <= cfg_data;
          REG_WINDOW:  win_r <= cfg_data;
          default:     ;
        endcase
      end
      if (in_acc) begin
        last_ctrl_r <= in_time_ms;
        if (samp_go) begin
          last_samp_time_r  <= in_time_ms;
          last_samp_count_r <= in_encoder_count;
        end
      end
      if (state_r == ST_SPEED) begin
        held_r <= held_c;
      end
      if (state_r == ST_INTEG) begin
        integ_r <= integ_sat;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      target_r  <= in_target_rpm;
      ctrl_dt_r <= ctrl_dt_c;
      samp_dt_r <= samp_dt_c;
      dabs_r    <= dabs_c;
      dneg_r    <= d_c[31];
    end
    unique case (state_r)
      ST_MUL_NUM: num_r <= mul_res[SPD_DIV_N-1:0];
      ST_MUL_DEN: begin
        div_dsr_r <= mul_res[DSR_W-1:0];
        div_quo_r <= DV_W'(num_r) << SH1;
        div_rem_r <= '0;
        div_cnt_r <= CNT_W'(SPD_DIV_N);
      end
      ST_MUL_P: begin
        err_abs_r <= err_abs_c;
        err_neg_r <= err_c[16];
        prod_r    <= mul_res[47:0];
      end
      ST_IABS: begin
        ineg_r    <= integ_r[IW-1];
        isat_r    <= (|iabs_w[DV_W-1:ISAT_BIT]) && (ki_r != 16'd0);
        div_dsr_r <= DSR_W'(MS_PER_S);
        div_quo_r <= DV_W'(iabs_w[INT_DIGITS*DIG_W-1:0]) << SH2;
        div_rem_r <= '0;
        div_cnt_r <= CNT_W'(INT_DIGITS);
      end
      ST_DIV_SPD: begin
        div_rem_r <= rem_sub[DSR_W-1:0];
        div_quo_r <= {div_quo_r[DV_W-2:0], div_ge};
        div_cnt_r <= div_cnt_r - CNT_W'(1);
      end
      ST_DIV_INT, ST_DIV_REM: begin
        div_rem_r <= DSR_W'(dig_r);
        div_quo_r <= {div_quo_r[DV_W-DIG_W-1:0], dig_q};
        div_cnt_r <= div_cnt_r - CNT_W'(1);
      end
      ST_MUL_Q: begin
        iq_r <= mul_res[49:0];
      end
      ST_MUL_R: begin
        div_dsr_r <= DSR_W'(MS_PER_S);
        div_quo_r <= DV_W'(mul_res[REM_DIGITS*DIG_W-1:0]) << SH3;
        div_rem_r <= '0;
        div_cnt_r <= CNT_W'(REM_DIGITS);
      end
      ST_MUL_KP: begin
        kpe_r <= mul_res[31:0];
        im_r  <= isat_r ? (51'(1) << ISAT_SH) : (51'(iq_r) + 51'(div_quo_r[15:0]));
      end
      ST_SUM: sum_r <= kpe_s + iterm_s;
      default: ;
    endcase
    if (out_load) begin
      out_mag_r     <= drive_c;
      out_forward_r <= fwd_c;
      out_rpm_r     <= held_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_drive_magnitude = out_mag_r;
  assign out_forward         = out_forward_r;
  assign out_measured_rpm    = out_rpm_r;

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_MUL_NUM) || (state_r == ST_MUL_P))
    else $error("accepted beat did not start the sequence");

  a_rem_below_dsr: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_DIV_SPD) || (state_r == ST_DIV_INT) || (state_r == ST_DIV_REM))
      |-> (div_rem_r < div_dsr_r))
    else $error("divider remainder not below divisor");

  a_reverse_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_forward) |-> (out_drive_magnitude != 8'd0))
    else $error("reverse direction with zero magnitude");

  a_fin_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_valid_r && (state_r == ST_IDLE)))
    else $error("finished result not presented");

endmodule

/* bench/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import espi_pkg::*;

  localparam int INTEG_W = 48;
  localparam longint INTEG_HI = (longint'(1) << (INTEG_W - 1)) - 1;
  localparam longint INTEG_LO = -INTEG_HI - 1;
  localparam int CYCLE_LIMIT = 1_000_000;

  typedef struct packed {
    logic [7:0]  magnitude;
    logic        forward;
    logic [15:0] rpm;
  } drive_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] in_target_rpm = '0;
  logic signed [31:0] in_encoder_count = '0;
  logic [31:0] in_time_ms = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] out_drive_magnitude;
  logic out_forward;
  logic signed [15:0] out_measured_rpm;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  logic [15:0] kp_reg = KP_RESET;
  logic [15:0] ki_reg = KI_RESET;
  logic [15:0] cpr_reg = CPR_RESET;
  logic [15:0] window_reg = WINDOW_RESET;

  logic [31:0] samp_time_ms = '0;
  logic [31:0] samp_count = '0;
  logic signed [15:0] held_rpm = '0;
  logic [31:0] ctrl_time_ms = '0;
  longint integ_acc = 0;

  drive_t drive_expect_q[$];
  drive_t exp_res;

  logic [31:0] clock_ms = '0;
  logic [31:0] enc_pos = '0;
  int enc_rate = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int n_calls = 0;
  int n_results = 0;
  int n_errors = 0;
  int cycle_count = 0;

  encoder_speed_pi_motor_drive #(
    .INTEGRATOR_WIDTH(INTEG_W)
  ) u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_target_rpm       (in_target_rpm),
    .in_encoder_count    (in_encoder_count),
    .in_time_ms          (in_time_ms),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_drive_magnitude (out_drive_magnitude),
    .out_forward         (out_forward),
    .out_measured_rpm    (out_measured_rpm),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic void predict_drive(input logic signed [15:0] tgt, input logic [31:0] enc,
                                        input logic [31:0] now);
    logic [31:0] ctrl_dt, samp_dt, dcount, dmag;
    longint win, cpr, num, den, spd, err, q, r, iterm, total, pwm;
    drive_t res;
    ctrl_dt = now - ctrl_time_ms;
    ctrl_time_ms = now;
    win = (window_reg == 16'd0) ? 64'sd1 : longint'(window_reg);
    samp_dt = now - samp_time_ms;
    if (longint'(samp_dt) >= win) begin
      dcount = enc - samp_count;
      samp_time_ms = now;
      samp_count = enc;
      cpr = (cpr_reg == 16'd0) ? 64'sd1 : longint'(cpr_reg);
      dmag = dcount[31] ? -dcount : dcount;
      num = 64'sd60000 * longint'(dmag);
      den = longint'(samp_dt) * cpr;
      spd = num / den;
      if (dcount[31]) begin
        held_rpm = (spd > 32768) ? 16'sh8000 : 16'(-spd);
      end else begin
        held_rpm = (spd > 32767) ? 16'sh7FFF : 16'(spd);
      end
    end
    err = longint'(tgt) - longint'(held_rpm);
    integ_acc = integ_acc + err * longint'(ctrl_dt);
    if (integ_acc > INTEG_HI) begin
      integ_acc = INTEG_HI;
    end else if (integ_acc < INTEG_LO) begin
      integ_acc = INTEG_LO;
    end
    q = integ_acc / 1000;
    r = integ_acc % 1000;
    if (ki_reg == 16'd0) begin
      iterm = 0;
    end else if (q >= (longint'(1) << 45)) begin
      iterm = longint'(1) << 62;
    end else if (q <= -(longint'(1) << 45)) begin
      iterm = -(longint'(1) << 62);
    end else begin
      iterm = longint'(ki_reg) * q + (longint'(ki_reg) * r) / 1000;
    end
    total = longint'(kp_reg) * err + iterm;
    pwm = total / 256;
    if (pwm > 255) begin
      pwm = 255;
    end else if (pwm < -255) begin
      pwm = -255;
    end
    res.magnitude = 8'((pwm < 0) ? -pwm : pwm);
    res.forward = (pwm >= 0);
    res.rpm = held_rpm;
    drive_expect_q.push_back(res);
  endfunction

  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (drive_expect_q.size() == 0) begin
        $error("result beat with no pending call: magnitude %0d forward %0d rpm %0d",
               out_drive_magnitude, out_forward, out_measured_rpm);
        n_errors++;
      end else begin
        exp_res = drive_expect_q.pop_front();
        n_results++;
        if (out_drive_magnitude !== exp_res.magnitude) begin
          $error("drive_magnitude: expected %0d, got %0d", exp_res.magnitude,
                 out_drive_magnitude);
          n_errors++;
        end
        if (out_forward !== exp_res.forward) begin
          $error("forward: expected %0d, got %0d", exp_res.forward, out_forward);
          n_errors++;
        end
        if (out_measured_rpm !== exp_res.rpm) begin
          $error("measured_rpm: expected %0d, got %0d", $signed(exp_res.rpm),
                 out_measured_rpm);
          n_errors++;
        end
      end
    end
  end

  task automatic send_call(input logic signed [15:0] tgt, input logic [31:0] enc,
                           input logic [31:0] now);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_target_rpm <= tgt;
    in_encoder_count <= enc;
    in_time_ms <= now;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    predict_drive(tgt, enc, now);
    n_calls++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (drive_expect_q.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    case (idx)
      REG_KP_GAIN: kp_reg = data;
      REG_KI_GAIN: ki_reg = data;
      REG_CPR:     cpr_reg = data;
      REG_WINDOW:  window_reg = data;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Two samples at a standstill bring the held speed to zero, then full-scale
  // error over long intervals drives the integrator back toward zero.
  task automatic unwind_integrator();
    longint left, dt;
    for (int k = 0; k < 2; k++) begin
      clock_ms += (window_reg == 16'd0) ? 32'd1 : 32'(window_reg);
      send_call(16'sd0, enc_pos, clock_ms);
    end
    for (int k = 0; k < 10 && integ_acc != 0; k++) begin
      left = (integ_acc < 0) ? -integ_acc : integ_acc;
      dt = left / 32767;
      if (dt > (longint'(1) << 31)) dt = longint'(1) << 31;
      if (dt == 0) break;
      clock_ms += 32'(dt);
      send_call((integ_acc < 0) ? 16'sd32767 : -16'sd32767, enc_pos, clock_ms);
    end
  endtask

  task automatic test_directed();
    send_call(16'sd0, 32'd0, 32'd0);
    send_call(16'sh8000, 32'd1024, 32'd100);
    send_call(16'sd0, -32'sd100000, 32'd200);
    send_call(16'sh7FFF, 32'd100000000, 32'd300);
    send_call(16'sd0, 32'h7FFF_FFFF, 32'd400);
    send_call(16'sd0, 32'h8000_0000, 32'd500);
    send_call(16'sd100, 32'h8000_0000, 32'd10);
    clock_ms = 32'd110;
    enc_pos = 32'h7F67_6980;
    send_call(16'sh7FFF, enc_pos, clock_ms);
    for (int k = 0; k < 4; k++) begin
      clock_ms += 32'h8000_0000;
      send_call(16'sh7FFF, enc_pos, clock_ms);
    end
    for (int k = 0; k < 5; k++) begin
      clock_ms += 32'h8000_0000;
      send_call(16'sh8000, enc_pos, clock_ms);
    end
    clock_ms = 32'hFFFF_FFFF;
    send_call(16'sd0, enc_pos, clock_ms);
    unwind_integrator();
  endtask

  task automatic test_degenerate_settings();
    wait_drained();
    write_reg(REG_CPR, 16'd0);
    write_reg(REG_WINDOW, 16'd0);
    send_call(16'sd1000, enc_pos, clock_ms);
    send_call(16'sd1000, enc_pos + 32'd1, clock_ms + 32'd1);
    send_call(16'sd1000, enc_pos - 32'd1, clock_ms + 32'd2);
    clock_ms += 32'd3;
    enc_pos -= 32'd1;
    send_call(-16'sd1000, enc_pos, clock_ms);
  endtask

  task automatic test_tracking_phase(input logic [15:0] kp, input logic [15:0] ki,
                                     input logic [15:0] cpr, input logic [15:0] win,
                                     input int idle_pct, input int stall_pct,
                                     input int n_track, input int n_noise);
    longint tgt;
    int dt;
    wait_drained();
    write_reg(REG_KP_GAIN, kp);
    write_reg(REG_KI_GAIN, ki);
    write_reg(REG_CPR, cpr);
    write_reg(REG_WINDOW, win);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < n_track; i++) begin
      if (i == n_track / 2) wait_drained();
      if (i % 16 == 0) enc_rate = $urandom_range(0, 600) - 300;
      if ($urandom_range(3) == 0) begin
        dt = $urandom_range(1, 2 * win + 1);
      end else begin
        dt = $urandom_range(1, 40);
      end
      clock_ms += dt;
      enc_pos += enc_rate * dt + $urandom_range(0, 6) - 3;
      tgt = longint'(held_rpm) + longint'($urandom_range(0, 400)) - 200;
      if (integ_acc > 64'sd200000) begin
        tgt -= 100;
      end else if (integ_acc < -64'sd200000) begin
        tgt += 100;
      end
      if (tgt > 32767) tgt = 32767;
      if (tgt < -32768) tgt = -32768;
      send_call(16'(tgt), enc_pos, clock_ms);
    end
    for (int i = 0; i < n_noise; i++) begin
      clock_ms = $urandom;
      enc_pos = $urandom;
      send_call(16'($urandom), enc_pos, clock_ms);
    end
    unwind_integrator();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_degenerate_settings();
    test_tracking_phase(KP_RESET, KI_RESET, CPR_RESET, WINDOW_RESET, 0, 0, 85, 12);
    test_tracking_phase(16'hFFFF, 16'd0, 16'd1, 16'd1, 62, 0, 85, 12);
    test_tracking_phase(16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 62, 85, 12);
    test_tracking_phase(16'($urandom), 16'($urandom_range(1, 2000)),
                        16'($urandom_range(1, 4096)), 16'($urandom_range(1, 300)),
                        31, 31, 85, 12);
    wait_drained();
    repeat (200) @(posedge clk);
    if (drive_expect_q.size() != 0) begin
      $error("%0d expected results never arrived", drive_expect_q.size());
      n_errors += drive_expect_q.size();
    end
    $display("Ran %0d control calls, %0d results compared, across reset, extreme and random",
             n_calls, n_results);
    $display("gain/encoder settings with free-running, gapped, stalled and mixed handshakes.");
    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* encoder_speed_pi_motor_drive.f */
hdl/espi_pkg.sv
hdl/encoder_speed_pi_motor_drive.sv
bench/tb.sv
